@@ hw/rtl/hill_pkg.sv @@
// Package for the 2x2 mod-26 Hill cipher: types and constants shared by
// front, queue and back, and the small mod-26 helpers used by front and back.
// No dependencies.
`default_nettype none

package hill_pkg;

	localparam int Modulus      = 26;
	// floor(x * Recip26 / 2^Recip26Shift) equals floor(x / 26) for x below 2^11
	localparam int Recip26      = 2521;
	localparam int Recip26Shift = 16;
	localparam int ModSq        = Modulus * Modulus;

	localparam int QueueDepth   = 2;   // power of two: pointers wrap naturally
	localparam int QueuePtrW    = $clog2(QueueDepth);
	localparam int QueueCntW    = QueuePtrW + 1;

	typedef logic [4:0]  letter_t;
	typedef logic [1:0]  reg_idx_t;
	typedef logic [10:0] wide_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_KEY_A = 2'd0,
		REG_KEY_B = 2'd1,
		REG_KEY_C = 2'd2,
		REG_KEY_D = 2'd3
	} reg_code_t;

	typedef struct packed {
		logic     we;
		reg_idx_t index;
		letter_t  data;
	} cfg_wr_t;

	// one classified item: coefficient matrix, scale factor, ok flag and letters
	typedef struct packed {
		letter_t m00;
		letter_t m01;
		letter_t m10;
		letter_t m11;
		letter_t scale;
		logic    ok;
		letter_t p0;
		letter_t p1;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	// 5-bit value reduced into 0..25
	function automatic letter_t red26(input letter_t v);
		letter_t r;
		r = (v >= letter_t'(Modulus)) ? v - letter_t'(Modulus) : v;
		return r;
	endfunction

	// 11-bit value mod 26 by reciprocal multiply and one correction
	function automatic letter_t mod26(input wide_t x);
		logic [22:0] prod;
		wide_t       quo;
		wide_t       rem;
		prod = 23'(x) * 23'(Recip26);
		quo  = wide_t'(prod >> Recip26Shift);
		rem  = x - wide_t'(quo * wide_t'(Modulus));
		if (rem >= wide_t'(Modulus)) begin
			rem = rem - wide_t'(Modulus);
		end
		return letter_t'(rem);
	endfunction

	// multiplicative inverse mod 26; 0 where none exists
	function automatic letter_t inv26(input letter_t v);
		letter_t r;
		case (v)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hill_if.sv @@
// Valid/ready channel interfaces for the Hill cipher: letter pairs in,
// result pairs out. Depends on hill_pkg.
`default_nettype none

interface hill_in_if
	import hill_pkg::*;
;
	logic    valid;
	logic    ready;
	logic    opcode;
	letter_t first_letter;
	letter_t second_letter;

	modport source (output valid, opcode, first_letter, second_letter, input ready);
	modport sink   (input valid, opcode, first_letter, second_letter, output ready);
endinterface

interface hill_out_if
	import hill_pkg::*;
;
	logic    valid;
	logic    ready;
	letter_t first_out;
	letter_t second_out;
	logic    key_ok;

	modport source (output valid, first_out, second_out, key_ok, input ready);
	modport sink   (input valid, first_out, second_out, key_ok, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hill_front.sv @@
// Front end: key registers, item intake and classification into commands.
// Depends on hill_pkg and hill_if.
`default_nettype none

module hill_front
	import hill_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_wr_t   cfg,
	hill_in_if.sink        pair,
	input  wire q_status_t q_stat,
	output logic           push,
	output cmd_t           push_data
);

	letter_t key_a_q, key_b_q, key_c_q, key_d_q;

	logic    valid_s1;
	opcode_t op_s1;
	letter_t p0_s1, p1_s1;
	logic [9:0] ad_s1, bc_s1;

	logic    load;
	letter_t det;
	logic    ok;
	letter_t nb, nc;

	// keys are stored already reduced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= 5'd1;
			key_b_q <= 5'd0;
			key_c_q <= 5'd0;
			key_d_q <= 5'd1;
		end else if (cfg.we) begin
			case (reg_code_t'(cfg.index))
				REG_KEY_A: key_a_q <= red26(cfg.data);
				REG_KEY_B: key_b_q <= red26(cfg.data);
				REG_KEY_C: key_c_q <= red26(cfg.data);
				REG_KEY_D: key_d_q <= red26(cfg.data);
				default:   ;
			endcase
		end
	end

	assign pair.ready = !valid_s1 || !q_stat.full;
	assign load       = pair.valid && pair.ready;
	assign push       = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// the user keeps the key static while items are in flight (not enforced here), so its products ride along here
	always_ff @(posedge clk) begin
		if (load) begin
			op_s1 <= opcode_t'(pair.opcode);
			p0_s1 <= red26(pair.first_letter);
			p1_s1 <= red26(pair.second_letter);
			ad_s1 <= 10'(key_a_q) * 10'(key_d_q);
			bc_s1 <= 10'(key_b_q) * 10'(key_c_q);
		end
	end

	always_comb begin
		det = mod26(wide_t'(ad_s1) + wide_t'(ModSq) - wide_t'(bc_s1));
		ok  = det[0] && (det != letter_t'(Modulus / 2));
		nb  = (key_b_q == '0) ? '0 : letter_t'(Modulus) - key_b_q;
		nc  = (key_c_q == '0) ? '0 : letter_t'(Modulus) - key_c_q;

		push_data.ok = ok;
		push_data.p0 = p0_s1;
		push_data.p1 = p1_s1;
		case (op_s1)
			OP_ENCRYPT: begin
				push_data.m00   = key_a_q;
				push_data.m01   = key_b_q;
				push_data.m10   = key_c_q;
				push_data.m11   = key_d_q;
				push_data.scale = 5'd1;
			end
			OP_DECRYPT: begin
				push_data.m00   = key_d_q;
				push_data.m01   = nb;
				push_data.m10   = nc;
				push_data.m11   = key_a_q;
				push_data.scale = inv26(det);
			end
			default: begin
				push_data.m00   = '0;
				push_data.m01   = '0;
				push_data.m10   = '0;
				push_data.m11   = '0;
				push_data.scale = '0;
			end
		endcase
	end

	a_key_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(key_a_q < letter_t'(Modulus)) && (key_b_q < letter_t'(Modulus)) &&
		(key_c_q < letter_t'(Modulus)) && (key_d_q < letter_t'(Modulus)))
		else $error("key register holds an unreduced value");

endmodule

`default_nettype wire

@@ hw/rtl/hill_queue.sv @@
// Short command queue between front and back of the Hill cipher.
// Depends on hill_pkg.
`default_nettype none

module hill_queue
	import hill_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_data,
	input  wire logic  pop,
	output cmd_t       pop_data,
	output q_status_t  stat
);

	cmd_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QueueCntW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data      = mem_q[rd_ptr_q];
	assign stat.full     = (count_q == QueueCntW'(QueueDepth));
	assign stat.nonempty = (count_q != '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop) && (count_q <= QueueCntW'(QueueDepth)))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.nonempty)
		else $error("command queue underflow");

endmodule

`default_nettype wire

@@ hw/rtl/hill_back.sv @@
// Back end: matrix products mod 26, scaling and the output register.
// Depends on hill_pkg and hill_if.
`default_nettype none

module hill_back
	import hill_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_status_t q_stat,
	input  wire cmd_t      cmd,
	output logic           pop,
	hill_out_if.source     result
);

	logic    valid_s1, valid_s2, valid_s3;
	wide_t   sum0_s1, sum1_s1;
	letter_t scale_s1;
	logic    ok_s1;
	logic [9:0] prod0_s2, prod1_s2;
	logic    ok_s2;
	letter_t first_s3, second_s3;
	logic    ok_s3;

	logic adv1, adv2, adv3;

	assign adv3 = !valid_s3 || result.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign pop  = q_stat.nonempty && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= pop;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pop) begin
			sum0_s1  <= wide_t'(10'(cmd.m00) * 10'(cmd.p0)) +
			            wide_t'(10'(cmd.m01) * 10'(cmd.p1));
			sum1_s1  <= wide_t'(10'(cmd.m10) * 10'(cmd.p0)) +
			            wide_t'(10'(cmd.m11) * 10'(cmd.p1));
			scale_s1 <= cmd.scale;
			ok_s1    <= cmd.ok;
		end
		if (adv2 && valid_s1) begin
			prod0_s2 <= 10'(mod26(sum0_s1)) * 10'(scale_s1);
			prod1_s2 <= 10'(mod26(sum1_s1)) * 10'(scale_s1);
			ok_s2    <= ok_s1;
		end
		if (adv3 && valid_s2) begin
			// invalid key forces both letters to zero
			first_s3  <= ok_s2 ? mod26(wide_t'(prod0_s2)) : '0;
			second_s3 <= ok_s2 ? mod26(wide_t'(prod1_s2)) : '0;
			ok_s3     <= ok_s2;
		end
	end

	assign result.valid      = valid_s3;
	assign result.first_out  = first_s3;
	assign result.second_out = second_s3;
	assign result.key_ok     = ok_s3;

endmodule

`default_nettype wire

@@ hw/rtl/hill_cipher_2x2_mod26_top.sv @@
// Top level of the 2x2 mod-26 Hill cipher: key port, front, queue, back.
// Depends on hill_pkg, hill_if, hill_front, hill_queue and hill_back.
//
// Use:
//  - Key: write cfg_data to register cfg_index (0 key_a, 1 key_b, 2 key_c,
//    3 key_d) with cfg_we high, only while no item is in flight. Values
//    above 25 are stored reduced mod 26.
//  - pair: valid/ready channel carrying opcode (0 encrypt, 1 decrypt) and
//    two letter indices. An item moves when valid and ready are both high.
//  - result: valid/ready channel carrying the two result letters and
//    key_ok. With a key whose determinant is not coprime to 26 both
//    letters read 0 and key_ok is 0.
//  - Path: an item that is taken passes the front register, a queue slot,
//    two back stages and the output register.
//  - Throughput: one item per cycle while result.ready stays high, set by
//    the front register and the fully pipelined back multipliers.
//  - Stall: when result.ready is low the back holds; the two-entry queue
//    then fills and only after that does pair.ready fall.
//  - Reset: arst_n clears all valid flags and loads the identity key.
`default_nettype none

module hill_cipher_2x2_mod26_top
	import hill_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire reg_idx_t cfg_index,
	input  wire letter_t  cfg_data,
	hill_in_if.sink       pair,
	hill_out_if.source    result
);

	cfg_wr_t   cfg;
	q_status_t q_stat;
	cmd_t      push_data, pop_data;
	logic      push, pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// intake, key store and classification
	hill_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pair      (pair),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples intake from the arithmetic pipeline
	hill_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// products, scaling, output register
	hill_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.cmd    (pop_data),
		.pop    (pop),
		.result (result)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.key_ok) |->
		(result.first_out == '0) && (result.second_out == '0))
		else $error("invalid key item carries nonzero letters");

	a_letters_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		(result.first_out < letter_t'(Modulus)) &&
		(result.second_out < letter_t'(Modulus)))
		else $error("result letter out of range");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the 2x2 mod-26 Hill cipher top level.
// Needs hill_pkg, hill_if (hill_in_if, hill_out_if) and hill_cipher_2x2_mod26_top.
`timescale 1ns / 1ps

module tb_top;
	import hill_pkg::*;

	localparam int unsigned Mod        = Modulus;
	localparam int          DirRows    = 53;
	localparam int          RandPhases = 8;
	localparam int          PhaseItems = 154;
	localparam int          HoldCycles = 64;   // long receiver hold-off
	localparam int          HoldAtItem = 40;
	localparam int          MaxReports = 10;

	// one result item as the block should produce it
	typedef struct packed {
		letter_t first_out;
		letter_t second_out;
		logic    key_ok;
	} cipher_res_t;

	typedef enum logic {
		ROW_KEY  = 1'b0,
		ROW_PAIR = 1'b1
	} row_kind_t;

	// directed row: a key write (sel, data in l0) or a letter pair
	typedef struct packed {
		row_kind_t   kind;
		reg_code_t   sel;
		opcode_t     op;
		letter_t     l0;
		letter_t     l1;
		logic        typed;   // want holds the expected item, else predicted
		cipher_res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	letter_t  cfg_data;

	hill_in_if  pair_ch ();
	hill_out_if result_ch ();

	hill_cipher_2x2_mod26_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair      (pair_ch),
		.result    (result_ch)
	);

	// Testbench copy of the key registers, raw 5-bit values as written.
	letter_t     key_regs [4];
	letter_t     next_key [4];
	cipher_res_t expected_pairs [$];

	int  error_count;
	int  report_count;
	int  n_items;
	int  n_decrypt;
	int  n_badkey;
	int  n_key_sets;
	int  in_stall_cycles;
	int  burst_left;
	bit  tx_gaps;
	int  rx_style;        // 0: always ready, 1: random stall pattern
	bit  hold_req;        // raised by the stimulus, cleared by the receiver
	int  rx_run_left;
	bit  rx_run_level;
	int  row_i;
	int  phase;
	int  item_i;
	int  r;
	bit  writing;
	bit  want_valid;
	cipher_res_t mon_got;
	cipher_res_t mon_want;

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Directed stimulus. Typed rows: identity key (reset value), and every
	// unusable key, which must give zero letters and key_ok low.
	dir_row_t dir_rows [DirRows] = '{
		// identity key after reset; values above 25 come back reduced
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd0,  5'd0,  1'b1, '{5'd0,  5'd0,  1'b1}},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd25, 5'd25, 1'b1, '{5'd25, 5'd25, 1'b1}},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd31, 5'd26, 1'b1, '{5'd5,  5'd0,  1'b1}},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd13, 5'd7,  1'b1, '{5'd13, 5'd7,  1'b1}},
		// textbook key, determinant 9
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd3,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd3,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd2,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd5,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd7,  5'd4,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd7,  5'd4,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd31, 5'd31, 1'b0, '0},
		// all-zero key: determinant zero
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd25, 5'd25, 1'b1, '{5'd0,  5'd0,  1'b0}},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd3,  5'd4,  1'b1, '{5'd0,  5'd0,  1'b0}},
		// determinant 13: odd but shares a factor with 26
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd13, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd1,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd1,  5'd1,  1'b1, '{5'd0,  5'd0,  1'b0}},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd2,  5'd2,  1'b1, '{5'd0,  5'd0,  1'b0}},
		// even determinant
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd2,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd5,  5'd5,  1'b1, '{5'd0,  5'd0,  1'b0}},
		// determinant zero although no entry is zero
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd13, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd13, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd1,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd1,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd4,  5'd4,  1'b1, '{5'd0,  5'd0,  1'b0}},
		// all ones in every register
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd31, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd31, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd31, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd31, 5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd30, 5'd1,  1'b1, '{5'd0,  5'd0,  1'b0}},
		// largest in-range diagonal
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd25, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd25, 5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd1,  5'd2,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd31, 5'd0,  1'b0, '0},
		// key values above 25
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd27, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd30, 5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd0,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd29, 5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd31, 5'd25, 1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd26, 5'd1,  1'b0, '0},
		// b*c larger than a*d: raw determinant negative
		'{ROW_KEY,  REG_KEY_A, OP_ENCRYPT, 5'd2,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_B, OP_ENCRYPT, 5'd5,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_C, OP_ENCRYPT, 5'd1,  5'd0,  1'b0, '0},
		'{ROW_KEY,  REG_KEY_D, OP_ENCRYPT, 5'd1,  5'd0,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_ENCRYPT, 5'd16, 5'd9,  1'b0, '0},
		'{ROW_PAIR, REG_KEY_A, OP_DECRYPT, 5'd16, 5'd9,  1'b0, '0}
	};

	// Determinant mod 26 of a key, each entry reduced first.
	function automatic int unsigned key_det(letter_t ka, letter_t kb, letter_t kc,
			letter_t kd);
		int unsigned a, b, c, d;
		a = ka % Mod;
		b = kb % Mod;
		c = kc % Mod;
		d = kd % Mod;
		return (a * d + Mod * Mod - b * c) % Mod;
	endfunction

	// Invertible mod 26: odd and not 13.
	function automatic bit det_coprime(int unsigned det);
		return (det % 2 == 1) && (det != 13);
	endfunction

	// Expected result item for one pair under the current key.
	function automatic cipher_res_t hill_pair_cipher(opcode_t op, letter_t l0, letter_t l1);
		int unsigned a, b, c, d, p0, p1, det, inv, i, s0, s1;
		cipher_res_t res;
		a   = key_regs[REG_KEY_A] % Mod;
		b   = key_regs[REG_KEY_B] % Mod;
		c   = key_regs[REG_KEY_C] % Mod;
		d   = key_regs[REG_KEY_D] % Mod;
		p0  = l0 % Mod;
		p1  = l1 % Mod;
		det = key_det(key_regs[REG_KEY_A], key_regs[REG_KEY_B],
			key_regs[REG_KEY_C], key_regs[REG_KEY_D]);
		res = '0;
		if (det_coprime(det)) begin
			res.key_ok = 1'b1;
			if (op == OP_ENCRYPT) begin
				s0 = (a * p0 + b * p1) % Mod;
				s1 = (c * p0 + d * p1) % Mod;
			end else begin
				inv = 0;
				for (i = 1; i < Mod; i++) begin
					if ((det * i) % Mod == 1) begin
						inv = i;
					end
				end
				// adjugate times pair, then scale by the inverse determinant
				s0 = (((d * p0 + ((Mod - b) % Mod) * p1) % Mod) * inv) % Mod;
				s1 = (((((Mod - c) % Mod) * p0 + a * p1) % Mod) * inv) % Mod;
			end
			res.first_out  = letter_t'(s0);
			res.second_out = letter_t'(s1);
		end
		return res;
	endfunction

	// Mostly in range, now and then 26..31 so the top bits get exercised.
	function automatic letter_t rand_field();
		if ($urandom_range(0, 9) == 0) begin
			return letter_t'($urandom_range(26, 31));
		end
		return letter_t'($urandom_range(0, 25));
	endfunction

	// Offer one pair until taken, then queue what should come back.
	task automatic drive_pair(input opcode_t op, input letter_t l0, input letter_t l1,
			input logic typed, input cipher_res_t want);
		cipher_res_t res;
		@(negedge clk);
		pair_ch.valid         = 1'b1;
		pair_ch.opcode        = op;
		pair_ch.first_letter  = l0;
		pair_ch.second_letter = l1;
		do begin
			@(posedge clk);
		end while (pair_ch.ready !== 1'b1);
		res = typed ? want : hill_pair_cipher(op, l0, l1);
		expected_pairs.insert(expected_pairs.size(), res);
		n_items++;
		if (op == OP_DECRYPT) begin
			n_decrypt++;
		end
		if (!res.key_ok) begin
			n_badkey++;
		end
	endtask

	// Sender gap (n >= 1): drop valid; n sets how long it stays low.
	task automatic idle_sender(input int n);
		@(negedge clk);
		pair_ch.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Stop offering and wait for every outstanding item to come back.
	task automatic drain_pairs();
		@(negedge clk);
		pair_ch.valid = 1'b0;
		while (expected_pairs.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Key write: one per falling edge; the caller lowers cfg_we afterwards.
	task automatic write_key(input reg_code_t sel, input letter_t val);
		@(negedge clk);
		cfg_we        = 1'b1;
		cfg_index     = reg_idx_t'(sel);
		cfg_data      = val;
		key_regs[sel] = val;
	endtask

	task automatic end_key_writes();
		@(negedge clk);
		cfg_we = 1'b0;
		n_key_sets++;
	endtask

	// Receiver: ready changes on the falling edge. A hold request drops ready
	// for HoldCycles, counted here, so the queue and the input back up.
	initial begin
		result_ch.ready = 1'b0;
		rx_run_left     = 0;
		rx_run_level    = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready = 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_style == 0) begin
				result_ch.ready = 1'b1;
			end else begin
				if (rx_run_left == 0) begin
					rx_run_level = !rx_run_level;
					rx_run_left  = rx_run_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
				end
				result_ch.ready = rx_run_level;
				rx_run_left--;
			end
		end
	end

	// Checks each taken result against the oldest expectation; counts input stalls.
	always @(posedge clk) begin
		if (arst_n && pair_ch.valid === 1'b1 && pair_ch.ready !== 1'b1) begin
			in_stall_cycles++;
		end
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			mon_got.first_out  = result_ch.first_out;
			mon_got.second_out = result_ch.second_out;
			mon_got.key_ok     = result_ch.key_ok;
			if (expected_pairs.size() == 0) begin
				error_count++;
				if (report_count < MaxReports) begin
					report_count++;
					$display("%0t: result %0d/%0d ok=%0b with nothing outstanding", $realtime,
						mon_got.first_out, mon_got.second_out, mon_got.key_ok);
				end
			end else begin
				mon_want = expected_pairs.pop_front();
				if (mon_got.first_out !== mon_want.first_out
						|| mon_got.second_out !== mon_want.second_out
						|| mon_got.key_ok !== mon_want.key_ok) begin
					error_count++;
					if (report_count < MaxReports) begin
						report_count++;
						$display("%0t: mismatch, expected %0d/%0d ok=%0b, got %0d/%0d ok=%0b",
							$realtime, mon_want.first_out, mon_want.second_out,
							mon_want.key_ok, mon_got.first_out, mon_got.second_out,
							mon_got.key_ok);
					end
				end
			end
		end
	end

	// Run limit, well above the slowest legal run.
	initial begin
		#400000;
		$display("Timeout with %0d items still outstanding", expected_pairs.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main stimulus
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		pair_ch.valid         = 1'b0;
		pair_ch.opcode        = 1'b0;
		pair_ch.first_letter  = '0;
		pair_ch.second_letter = '0;
		key_regs[REG_KEY_A]   = 5'd1;   // identity key out of reset
		key_regs[REG_KEY_B]   = 5'd0;
		key_regs[REG_KEY_C]   = 5'd0;
		key_regs[REG_KEY_D]   = 5'd1;
		error_count           = 0;
		report_count          = 0;
		n_items               = 0;
		n_decrypt             = 0;
		n_badkey              = 0;
		n_key_sets            = 1;
		in_stall_cycles       = 0;
		burst_left            = 0;
		tx_gaps               = 1'b0;
		rx_style              = 1;
		hold_req              = 1'b0;
		writing               = 1'b0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. Key rows are grouped: drain first, write the group,
		// then drop the write enable before the next pair.
		for (row_i = 0; row_i < DirRows; row_i++) begin
			if (dir_rows[row_i].kind == ROW_KEY) begin
				if (!writing) begin
					drain_pairs();
					writing = 1'b1;
				end
				write_key(dir_rows[row_i].sel, dir_rows[row_i].l0);
			end else begin
				if (writing) begin
					end_key_writes();
					writing = 1'b0;
				end
				drive_pair(dir_rows[row_i].op, dir_rows[row_i].l0, dir_rows[row_i].l1,
					dir_rows[row_i].typed, dir_rows[row_i].want);
			end
		end

		// Random phases, each with a fresh key written in full while idle.
		// Phase 0 runs at full rate both sides; phase 1 carries the long hold;
		// phase 5 uses a key that cannot be inverted.
		for (phase = 0; phase < RandPhases; phase++) begin
			want_valid = (phase != 5);
			do begin
				for (r = 0; r < 4; r++) begin
					next_key[r] = rand_field();
				end
			end while (det_coprime(key_det(next_key[0], next_key[1], next_key[2],
				next_key[3])) != want_valid);
			drain_pairs();
			write_key(REG_KEY_A, next_key[0]);
			write_key(REG_KEY_B, next_key[1]);
			write_key(REG_KEY_C, next_key[2]);
			write_key(REG_KEY_D, next_key[3]);
			end_key_writes();

			tx_gaps    = (phase > 1) && ($urandom_range(0, 3) != 0);
			rx_style   = (phase == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 0 : 1);
			burst_left = 0;
			for (item_i = 0; item_i < PhaseItems; item_i++) begin
				if (phase == 1 && item_i == HoldAtItem) begin
					hold_req = 1'b1;
				end
				if (tx_gaps && burst_left == 0) begin
					idle_sender($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
				if (burst_left > 0) begin
					burst_left--;
				end
				drive_pair(opcode_t'($urandom_range(0, 1)), rand_field(), rand_field(),
					1'b0, '0);
			end
		end

		// Everything sent: wait for the tail, then let the clock run on before the report.
		drain_pairs();
		repeat (8) @(posedge clk);

		$display("Covered %0d letter pairs (%0d decrypt) over %0d key settings,",
			n_items, n_decrypt, n_key_sets);
		$display("%0d under an unusable key; input held off for %0d cycles.",
			n_badkey, in_stall_cycles);
		if (error_count == 0 && expected_pairs.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors, %0d items unanswered", error_count, expected_pairs.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/hill_pkg.sv
hw/rtl/hill_if.sv
hw/rtl/hill_front.sv
hw/rtl/hill_queue.sv
hw/rtl/hill_back.sv
hw/rtl/hill_cipher_2x2_mod26_top.sv
verif/tb_top.sv
